[rtl/alcs_pkg.sv]
package alcs_pkg;

  // fixed widths of the item and result words
  localparam int IN_COORD_W = 20;
  localparam int IN_LAYER_W = 4;
  localparam int IN_SLOT_W  = 4;
  localparam int OUT_SLOT_W = 4;
  localparam int OUT_MASK_W = 16;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // scan sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SRC  = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

endpackage

[rtl/alcs_ram.sv]
module alcs_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/aabb_layer_collision_scan.sv]
// a write word takes effect at the accept edge and gives no result
// a tick word gives one result row per source slot, slot 0 first; the rows
// are paced by the single edge ram read port and the one shared overlap
// comparator, busy stays high throughout
// results are strobed for one cycle on hit_valid; the receiver cannot stall
// reset (rst, synchronous) clears the sequencer and every slot's flags
module aabb_layer_collision_scan
  import alcs_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int COORD_BITS = 20,
  parameter int LAYER_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [IN_SLOT_W-1:0]         slot,
  input  logic signed [IN_COORD_W-1:0] box_left,
  input  logic signed [IN_COORD_W-1:0] box_top,
  input  logic signed [IN_COORD_W-1:0] box_right,
  input  logic signed [IN_COORD_W-1:0] box_bottom,
  input  logic                         entry_enabled,
  input  logic [IN_LAYER_W-1:0]        source_layer,
  input  logic [IN_LAYER_W-1:0]        target_layer,
  input  logic                         wants_notice,
  output logic                         hit_valid,
  output logic [OUT_SLOT_W-1:0]        src_slot,
  output logic [OUT_MASK_W-1:0]        hit_mask,
  output logic                         last
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  // one bit above both index widths so that NUM_SLOTS itself fits
  localparam int IDX_W = ((SW > IN_SLOT_W) ? SW : IN_SLOT_W) + 1;
  localparam int EDGE_W = 4 * COORD_BITS;

  // edge ram word layout: left, top, right, bottom from msb down
  localparam int L_LO = 3 * COORD_BITS;
  localparam int T_LO = 2 * COORD_BITS;
  localparam int R_LO = COORD_BITS;

  // per slot flags, cleared by reset
  logic                  en_q     [NUM_SLOTS];
  logic [LAYER_BITS-1:0] src_ly_q [NUM_SLOTS];
  logic [LAYER_BITS-1:0] tgt_ly_q [NUM_SLOTS];
  logic                  ntf_q    [NUM_SLOTS];

  state_t state, state_next;

  logic          accept;
  logic          wr_item;
  logic          tick_item;
  logic [IDX_W-1:0] slot_wide;
  logic          slot_ok;
  logic [SW-1:0] wr_addr;
  logic [EDGE_W-1:0] wr_data;

  logic [SW-1:0]   s_idx;      // current source slot
  logic [SW:0]     d_idx;      // next destination read address
  logic [SW-1:0]   cmp_idx;    // destination whose edges are on rd_data
  logic            cmp_vld;
  logic [SW-1:0]   rd_addr;
  logic [EDGE_W-1:0] rd_data;

  // latched source box
  logic signed [COORD_BITS-1:0] s_left, s_top, s_right, s_bottom;
  logic                  s_active;
  logic [LAYER_BITS-1:0] s_tgt;

  logic signed [COORD_BITS-1:0] d_left, d_top, d_right, d_bottom;
  logic                 overlap;
  logic                 hit;
  logic [NUM_SLOTS-1:0] mask, mask_next;
  logic                 scan_end;

  assign accept    = start && !busy;
  assign wr_item   = accept && (func == FUNC_WRITE);
  assign tick_item = accept && (func == FUNC_TICK);
  assign busy      = (state != ST_IDLE);

  // writes beyond the table are dropped
  assign slot_wide = IDX_W'(slot);
  assign slot_ok   = (slot_wide < IDX_W'(NUM_SLOTS));
  assign wr_addr   = slot_wide[SW-1:0];
  assign wr_data   = {COORD_BITS'(box_left), COORD_BITS'(box_top),
                      COORD_BITS'(box_right), COORD_BITS'(box_bottom)};

  alcs_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (NUM_SLOTS)
  ) u_edges (
    .clk   (clk),
    .we    (wr_item && slot_ok),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // source read in ST_SRC, destinations streamed from ST_LOAD on
  always_comb begin
    rd_addr = s_idx;
    if (state == ST_LOAD) begin
      rd_addr = '0;
    end else if (state == ST_SCAN) begin
      rd_addr = d_idx[SW-1:0];
    end
  end

  // shared overlap comparator, strict signed edges
  assign d_left   = rd_data[L_LO +: COORD_BITS];
  assign d_top    = rd_data[T_LO +: COORD_BITS];
  assign d_right  = rd_data[R_LO +: COORD_BITS];
  assign d_bottom = rd_data[0 +: COORD_BITS];

  assign overlap = (s_left < d_right) && (s_right > d_left) &&
                   (s_top < d_bottom) && (s_bottom > d_top);

  // a source never reports itself; only notifying boxes on the target layer
  assign hit = cmp_vld && s_active && (cmp_idx != s_idx) && en_q[cmp_idx] &&
               (src_ly_q[cmp_idx] == s_tgt) && ntf_q[cmp_idx] && overlap;

  always_comb begin
    mask_next = mask;
    if (hit) begin
      mask_next[cmp_idx] = 1'b1;
    end
  end

  assign scan_end = (state == ST_SCAN) && (d_idx == (SW + 1)'(NUM_SLOTS));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_item) state_next = ST_SRC;
      end
      ST_SRC:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_next = (s_idx == SW'(NUM_SLOTS - 1)) ? ST_IDLE : ST_SRC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s_idx     <= '0;
      d_idx     <= '0;
      cmp_vld   <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hit_valid <= scan_end;
      unique case (state)
        ST_IDLE: begin
          s_idx   <= '0;
          cmp_vld <= 1'b0;
        end
        ST_SRC: begin
          cmp_vld <= 1'b0;
        end
        ST_LOAD: begin
          cmp_vld <= 1'b1;
          d_idx   <= (SW + 1)'(1);
        end
        ST_SCAN: begin
          if (scan_end) begin
            cmp_vld <= 1'b0;
            s_idx   <= s_idx + 1'b1;
          end else begin
            d_idx <= d_idx + 1'b1;
          end
        end
        default: begin
          cmp_vld <= 1'b0;
        end
      endcase
    end
  end

  // payload: source latch, destination pointer, mask and result word
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      s_left   <= rd_data[L_LO +: COORD_BITS];
      s_top    <= rd_data[T_LO +: COORD_BITS];
      s_right  <= rd_data[R_LO +: COORD_BITS];
      s_bottom <= rd_data[0 +: COORD_BITS];
      s_active <= en_q[s_idx] && (tgt_ly_q[s_idx] != '0);
      s_tgt    <= tgt_ly_q[s_idx];
      cmp_idx  <= '0;
      mask     <= '0;
    end else if (state == ST_SCAN) begin
      mask <= mask_next;
      if (!scan_end) begin
        cmp_idx <= d_idx[SW-1:0];
      end
    end
    if (scan_end) begin
      src_slot <= OUT_SLOT_W'(s_idx);
      hit_mask <= OUT_MASK_W'(mask_next);
      last     <= (s_idx == SW'(NUM_SLOTS - 1));
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        en_q[i]     <= 1'b0;
        src_ly_q[i] <= '0;
        tgt_ly_q[i] <= '0;
        ntf_q[i]    <= 1'b0;
      end
    end else if (wr_item && slot_ok) begin
      en_q[wr_addr]     <= entry_enabled;
      src_ly_q[wr_addr] <= LAYER_BITS'(source_layer);
      tgt_ly_q[wr_addr] <= LAYER_BITS'(target_layer);
      ntf_q[wr_addr]    <= wants_notice;
    end
  end

endmodule

[verif/hit_row_checker.sv]
`timescale 1ns / 1ps

module hit_row_checker
  import alcs_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         func,
  input  logic [IN_SLOT_W-1:0]         slot,
  input  logic signed [IN_COORD_W-1:0] box_left,
  input  logic signed [IN_COORD_W-1:0] box_top,
  input  logic signed [IN_COORD_W-1:0] box_right,
  input  logic signed [IN_COORD_W-1:0] box_bottom,
  input  logic                         entry_enabled,
  input  logic [IN_LAYER_W-1:0]        source_layer,
  input  logic [IN_LAYER_W-1:0]        target_layer,
  input  logic                         wants_notice,
  input  logic                         hit_valid,
  input  logic [OUT_SLOT_W-1:0]        src_slot,
  input  logic [OUT_MASK_W-1:0]        hit_mask,
  input  logic                         last,
  output int                           error_count,
  output int                           rows_pending
);

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] src;
    logic [OUT_MASK_W-1:0] mask;
    logic                  last;
  } hit_row_t;

  // own copy of the box table
  logic signed [IN_COORD_W-1:0] box_l_q [NUM_SLOTS];
  logic signed [IN_COORD_W-1:0] box_t_q [NUM_SLOTS];
  logic signed [IN_COORD_W-1:0] box_r_q [NUM_SLOTS];
  logic signed [IN_COORD_W-1:0] box_b_q [NUM_SLOTS];
  logic                         en_q [NUM_SLOTS];
  logic [IN_LAYER_W-1:0]        src_layer_q [NUM_SLOTS];
  logic [IN_LAYER_W-1:0]        tgt_layer_q [NUM_SLOTS];
  logic                         notice_q [NUM_SLOTS];

  hit_row_t queued_hit_rows[$];
  int       mismatches = 0;
  int       queued_count = 0;

  assign error_count  = mismatches;
  assign rows_pending = queued_count;

  function automatic logic boxes_overlap(int s, int d);
    return box_l_q[s] < box_r_q[d] && box_r_q[s] > box_l_q[d] &&
           box_t_q[s] < box_b_q[d] && box_b_q[s] > box_t_q[d];
  endfunction

  // one row per slot, slot 0 first; edges are read only for enabled slots
  task automatic predict_scan();
    hit_row_t row;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      row = '0;
      row.src  = OUT_SLOT_W'(s);
      row.last = (s == NUM_SLOTS - 1);
      if (en_q[s] && tgt_layer_q[s] != '0) begin
        for (int d = 0; d < NUM_SLOTS; d++) begin
          if (d != s && d < OUT_MASK_W && en_q[d] && notice_q[d] &&
              src_layer_q[d] == tgt_layer_q[s] && boxes_overlap(s, d))
            row.mask[d] = 1'b1;
        end
      end
      queued_hit_rows = {queued_hit_rows, row};
    end
  endtask

  task automatic note_mismatch(string field, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, exp_val, act_val);
  endtask

  always @(posedge clk) begin : watch
    hit_row_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) en_q[i] = 1'b0;
    end else begin
      // results first: a word accepted at this edge cannot have caused one yet
      if (hit_valid) begin
        if (queued_hit_rows.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected row, expected none actual slot %0h mask %0h last %0b",
                   $time, src_slot, hit_mask, last);
        end else begin
          want = queued_hit_rows.pop_front();
          if (src_slot !== want.src) note_mismatch("src_slot", want.src, src_slot);
          if (hit_mask !== want.mask) note_mismatch("hit_mask", want.mask, hit_mask);
          if (last !== want.last) note_mismatch("last", want.last, last);
        end
      end
      if (start && !busy) begin
        if (func == FUNC_WRITE) begin
          if (slot < NUM_SLOTS) begin
            box_l_q[slot]     = box_left;
            box_t_q[slot]     = box_top;
            box_r_q[slot]     = box_right;
            box_b_q[slot]     = box_bottom;
            en_q[slot]        = entry_enabled;
            src_layer_q[slot] = source_layer;
            tgt_layer_q[slot] = target_layer;
            notice_q[slot]    = wants_notice;
          end
        end else begin
          predict_scan();
        end
      end
    end
    queued_count = queued_hit_rows.size();
  end

endmodule

[verif/aabb_layer_collision_scan_tb.sv]
`timescale 1ns / 1ps

module aabb_layer_collision_scan_tb;
  import alcs_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int RANDOM_WORDS = 354;
  localparam int DRAIN_EVERY  = 70;
  localparam int DRAIN_LIMIT  = 2000;
  // long enough for a whole tick to finish, with some margin
  localparam int TAIL_CYCLES  = 320;

  localparam logic signed [IN_COORD_W-1:0] COORD_MIN = {1'b1, {(IN_COORD_W-1){1'b0}}};
  localparam logic signed [IN_COORD_W-1:0] COORD_MAX = {1'b0, {(IN_COORD_W-1){1'b1}}};

  // every input known from time zero
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         func = FUNC_WRITE;
  logic [IN_SLOT_W-1:0]         slot = '0;
  logic signed [IN_COORD_W-1:0] box_left = '0;
  logic signed [IN_COORD_W-1:0] box_top = '0;
  logic signed [IN_COORD_W-1:0] box_right = '0;
  logic signed [IN_COORD_W-1:0] box_bottom = '0;
  logic                         entry_enabled = 1'b0;
  logic [IN_LAYER_W-1:0]        source_layer = '0;
  logic [IN_LAYER_W-1:0]        target_layer = '0;
  logic                         wants_notice = 1'b0;

  logic                  busy;
  logic                  hit_valid;
  logic [OUT_SLOT_W-1:0] src_slot;
  logic [OUT_MASK_W-1:0] hit_mask;
  logic                  last;

  int error_count;
  int rows_pending;
  int burst_left = 0;

  always #4 clk = ~clk;

  aabb_layer_collision_scan #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .slot          (slot),
    .box_left      (box_left),
    .box_top       (box_top),
    .box_right     (box_right),
    .box_bottom    (box_bottom),
    .entry_enabled (entry_enabled),
    .source_layer  (source_layer),
    .target_layer  (target_layer),
    .wants_notice  (wants_notice),
    .hit_valid     (hit_valid),
    .src_slot      (src_slot),
    .hit_mask      (hit_mask),
    .last          (last)
  );

  // predicts every tick's rows and compares them as they stream out
  hit_row_checker #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_hit_row_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .slot          (slot),
    .box_left      (box_left),
    .box_top       (box_top),
    .box_right     (box_right),
    .box_bottom    (box_bottom),
    .entry_enabled (entry_enabled),
    .source_layer  (source_layer),
    .target_layer  (target_layer),
    .wants_notice  (wants_notice),
    .hit_valid     (hit_valid),
    .src_slot      (src_slot),
    .hit_mask      (hit_mask),
    .last          (last),
    .error_count   (error_count),
    .rows_pending  (rows_pending)
  );

  // hard stop, far beyond a run made of nothing but ticks and long gaps
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // present one word at the falling edge and hold it until the block takes it
  task automatic put_word(logic f, logic [IN_SLOT_W-1:0] s,
                          logic signed [IN_COORD_W-1:0] l, logic signed [IN_COORD_W-1:0] t,
                          logic signed [IN_COORD_W-1:0] r, logic signed [IN_COORD_W-1:0] b,
                          logic en, logic [IN_LAYER_W-1:0] sl, logic [IN_LAYER_W-1:0] tl,
                          logic wn);
    @(negedge clk);
    func          = f;
    slot          = s;
    box_left      = l;
    box_top       = t;
    box_right     = r;
    box_bottom    = b;
    entry_enabled = en;
    source_layer  = sl;
    target_layer  = tl;
    wants_notice  = wn;
    start         = 1'b1;
    // accepted at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
  endtask

  // tick word; the box fields are don't-care, so fill them with noise
  task automatic put_tick();
    put_word(FUNC_TICK, IN_SLOT_W'($urandom), IN_COORD_W'($urandom), IN_COORD_W'($urandom),
             IN_COORD_W'($urandom), IN_COORD_W'($urandom), 1'($urandom),
             IN_LAYER_W'($urandom), IN_LAYER_W'($urandom), 1'($urandom));
  endtask

  task automatic idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // hold off until every predicted row has come out
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (rows_pending != 0) @(negedge clk);
  endtask

  // mostly short gaps, a few long ones, and back-to-back bursts now and then
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 5) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // most words are clustered boxes on a few layers so that hits are common;
  // some are ticks and the rest is raw noise that walks every bit of every field
  task automatic random_word();
    int roll;
    int cx, cy, w, h;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      put_tick();
    end else if (roll < 27) begin
      put_word(1'($urandom), IN_SLOT_W'($urandom), IN_COORD_W'($urandom),
               IN_COORD_W'($urandom), IN_COORD_W'($urandom), IN_COORD_W'($urandom),
               1'($urandom), IN_LAYER_W'($urandom), IN_LAYER_W'($urandom), 1'($urandom));
    end else begin
      cx = $urandom_range(0, 320) - 160;
      cy = $urandom_range(0, 320) - 160;
      // a slightly negative size gives an inverted box now and then
      w  = $urandom_range(0, 140) - 8;
      h  = $urandom_range(0, 140) - 8;
      put_word(FUNC_WRITE, IN_SLOT_W'($urandom), IN_COORD_W'(cx), IN_COORD_W'(cy),
               IN_COORD_W'(cx + w), IN_COORD_W'(cy + h), $urandom_range(0, 9) != 0,
               IN_LAYER_W'($urandom_range(1, 3)), IN_LAYER_W'($urandom_range(0, 3)),
               $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin : stimulus
    int waited;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table: every row comes back with a clear mask
    put_tick();
    // layer 1 box aiming at layer 2, and a layer 2 box aiming back
    put_word(FUNC_WRITE, 4'd0, 20'sd0, 20'sd0, 20'sd16, 20'sd16, 1'b1, 4'd1, 4'd2, 1'b1);
    put_word(FUNC_WRITE, 4'd1, 20'sd8, 20'sd8, 20'sd24, 20'sd24, 1'b1, 4'd2, 4'd1, 1'b1);
    // shares only slot 0's right edge, strict compare gives no hit
    put_word(FUNC_WRITE, 4'd2, 20'sd16, 20'sd0, 20'sd32, 20'sd16, 1'b1, 4'd2, 4'd0, 1'b1);
    // source and target on its own layer: must never hit itself
    put_word(FUNC_WRITE, 4'd3, 20'sd0, 20'sd0, 20'sd16, 20'sd16, 1'b1, 4'd3, 4'd3, 1'b1);
    // overlaps slot 3 on layer 3 but has no hit handler
    put_word(FUNC_WRITE, 4'd4, 20'sd4, 20'sd4, 20'sd12, 20'sd12, 1'b1, 4'd3, 4'd0, 1'b0);
    // full coordinate range, top layer, hitting each other
    put_word(FUNC_WRITE, 4'd5, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
             1'b1, 4'd15, 4'd15, 1'b1);
    put_word(FUNC_WRITE, 4'd6, -20'sd16, -20'sd16, 20'sd16, 20'sd16, 1'b1, 4'd15, 4'd15, 1'b1);
    // overlaps slot 0 on layer 2, no handler
    put_word(FUNC_WRITE, 4'd14, 20'sd8, 20'sd8, 20'sd24, 20'sd24, 1'b1, 4'd2, 4'd0, 1'b0);
    // disabled box on layer 2 is never seen
    put_word(FUNC_WRITE, 4'd15, 20'sd8, 20'sd8, 20'sd24, 20'sd24, 1'b0, 4'd2, 4'd1, 1'b1);
    // target layer none: gets hit but its own row stays clear
    put_word(FUNC_WRITE, 4'd7, 20'sd0, 20'sd0, 20'sd16, 20'sd16, 1'b1, 4'd2, 4'd0, 1'b1);
    put_tick();
    // destroy slot 1
    put_word(FUNC_WRITE, 4'd1, 20'sd8, 20'sd8, 20'sd24, 20'sd24, 1'b0, 4'd2, 4'd1, 1'b1);
    // inverted box overlaps nothing
    put_word(FUNC_WRITE, 4'd8, 20'sd20, 20'sd20, -20'sd20, -20'sd20, 1'b1, 4'd1, 4'd2, 1'b1);
    // shares only slot 0's bottom edge
    put_word(FUNC_WRITE, 4'd9, 20'sd0, 20'sd16, 20'sd16, 20'sd32, 1'b1, 4'd2, 4'd0, 1'b1);
    // slot 15 comes alive at the far corner of the top layer
    put_word(FUNC_WRITE, 4'd15, COORD_MAX - 20'sd16, COORD_MAX - 20'sd16, COORD_MAX,
             COORD_MAX, 1'b1, 4'd15, 4'd15, 1'b1);
    put_tick();
    drain();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      random_word();
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
      else idle(pick_gap());
    end

    // wind down: let the last tick finish, then watch for stray rows
    @(negedge clk);
    start = 1'b0;
    waited = 0;
    while (rows_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (rows_pending != 0)
      $display("%0t ns: %0d hit rows never arrived", $time, rows_pending);
    if (error_count == 0 && rows_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
